FILE: sv/tlbpt_pkg.sv
package tlbpt_pkg;

    // sizing of the translator; page and tlb sizes are powers of two
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_BYTES  = 256;

    // fixed field widths
    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 8;
    localparam int FREE_W  = 9;
    localparam int CNT_W   = 16;

    // derived widths
    localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int OFF_W     = $clog2(PAGE_BYTES);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // tlb fill command from the sequencer
    typedef struct packed {
        logic                 we;
        logic [TLB_IDX_W-1:0] idx;
        logic [PAGE_W-1:0]    tag;
        logic [FRAME_W-1:0]   frame;
    } t_tlb_wr;

    // compare result for the slot under test
    typedef struct packed {
        logic               match;
        logic [FRAME_W-1:0] frame;
    } t_tlb_rd;

    // running count that stops at its maximum
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

FILE: sv/tlbpt_ram.sv
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tlbpt_tlb.sv
module tlbpt_tlb
    import tlbpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tlb_wr              i_wr,
    input  logic [TLB_IDX_W-1:0] i_rd_idx,
    input  logic [PAGE_W-1:0]    i_page,
    output t_tlb_rd              o_rd
);

    logic [TLB_ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]      r_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_frame [TLB_ENTRIES];

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    // tag and frame stores, read only under their valid bit
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_tag[i_wr.idx]   <= i_wr.tag;
            r_frame[i_wr.idx] <= i_wr.frame;
        end
    end

    // shared comparator: one slot per cycle
    assign o_rd.match = r_valid[i_rd_idx] && (r_tag[i_rd_idx] == i_page);
    assign o_rd.frame = r_frame[i_rd_idx];

endmodule

FILE: sv/tlb_page_table_translator_unit.sv
// Translates 16-bit logical addresses (page in the upper bits, offset in the
// lower bits) through a 16-slot TLB backed by a 256-entry page table, with
// demand allocation of frames on a page fault and FIFO refill of the TLB.
// One transaction at a time: o_ready is high only while the unit is idle.
// A single comparator walks the TLB one slot per cycle from slot 0, so an
// item that hits in slot k ends its walk at that slot, while a TLB miss
// walks all slots, then does one page-table read from the synchronous
// RAM, and the result is posted after that read. The result sits in an
// output register, so the next item is accepted and walked while a result
// waits; only its posting holds until the output register is emptied. After
// reset a clearing pass over all PAGE_COUNT entries invalidates the page table
// before the first transaction is accepted.
module tlb_page_table_translator_unit
    import tlbpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ADDR_W-1:0] i_logical_address,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_phys_addr,
    output logic              o_tlb_hit,
    output logic              o_page_fault,
    output logic [CNT_W-1:0]  o_hit_count,
    output logic [CNT_W-1:0]  o_fault_count,
    output logic [CNT_W-1:0]  o_access_count
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_TABLE,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [PAGE_W-1:0]    r_clr_addr, n_clr_addr;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [OFF_W-1:0]     r_offset, n_offset;
    logic [TLB_IDX_W-1:0] r_idx, n_idx;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic                 r_hit, n_hit;
    logic                 r_fault, n_fault;
    logic [TLB_IDX_W-1:0] r_fifo_slot, n_fifo_slot;
    logic [FREE_W-1:0]    r_free_frame, n_free_frame;
    logic [CNT_W-1:0]     r_hits, n_hits;
    logic [CNT_W-1:0]     r_faults, n_faults;
    logic [CNT_W-1:0]     r_accesses, n_accesses;
    logic                 r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]    r_out_pa, n_out_pa;
    logic                 r_out_hit, n_out_hit;
    logic                 r_out_fault, n_out_fault;

    t_tlb_wr tlb_wr;
    t_tlb_rd tlb_rd;

    logic                ram_we;
    logic [PAGE_W-1:0]   ram_waddr;
    logic [FRAME_W:0]    ram_wdata;
    logic                ram_re;
    logic [FRAME_W:0]    ram_rdata;
    logic                tbl_valid;
    logic [FRAME_W-1:0]  tbl_frame;
    logic [FRAME_W-1:0]  new_frame;
    logic                scan_last;
    logic [FRAME_W+OFF_W-1:0] pa_full;

    // tlb store with its slot comparator
    tlbpt_tlb u_tlb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tlb_wr),
        .i_rd_idx (r_idx),
        .i_page   (r_page),
        .o_rd     (tlb_rd)
    );

    // page table: resident bit over frame number
    tlbpt_ram #(
        .WIDTH (FRAME_W + 1),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_page),
        .o_rdata (ram_rdata)
    );

    assign tbl_valid = ram_rdata[FRAME_W];
    assign tbl_frame = ram_rdata[FRAME_W-1:0];
    assign new_frame = r_free_frame[FRAME_W-1:0];
    assign scan_last = (r_idx == TLB_IDX_W'(TLB_ENTRIES - 1));
    assign pa_full   = {r_frame, r_offset};

    // page table write port: clearing pass or fault allocation
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_page;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, new_frame};

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_page       = r_page;
        n_offset     = r_offset;
        n_idx        = r_idx;
        n_frame      = r_frame;
        n_hit        = r_hit;
        n_fault      = r_fault;
        n_fifo_slot  = r_fifo_slot;
        n_free_frame = r_free_frame;
        n_hits       = r_hits;
        n_faults     = r_faults;
        n_accesses   = r_accesses;
        n_out_valid  = r_out_valid;
        n_out_pa     = r_out_pa;
        n_out_hit    = r_out_hit;
        n_out_fault  = r_out_fault;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        tlb_wr.we    = 1'b0;
        tlb_wr.idx   = r_fifo_slot;
        tlb_wr.tag   = r_page;
        tlb_wr.frame = new_frame;

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + PAGE_W'(1);
                if (r_clr_addr == PAGE_W'(PAGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_page   = PAGE_W'(i_logical_address >> OFF_W);
                    n_offset = i_logical_address[OFF_W-1:0];
                    n_idx    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tlb_rd.match) begin
                    n_hit   = 1'b1;
                    n_fault = 1'b0;
                    n_frame = tlb_rd.frame;
                    n_state = S_DONE;
                end else if (scan_last) begin
                    ram_re  = 1'b1;
                    n_state = S_TABLE;
                end else begin
                    n_idx = r_idx + TLB_IDX_W'(1);
                end
            end
            S_TABLE: begin
                n_hit = 1'b0;
                if (tbl_valid) begin
                    n_fault = 1'b0;
                    n_frame = tbl_frame;
                end else begin
                    // page fault: allocate frame, fill table and tlb slot
                    n_fault      = 1'b1;
                    n_frame      = new_frame;
                    ram_we       = 1'b1;
                    tlb_wr.we    = 1'b1;
                    n_free_frame = r_free_frame + FREE_W'(1);
                    n_fifo_slot  = (r_fifo_slot == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                                   '0 : r_fifo_slot + TLB_IDX_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pa    = ADDR_W'(pa_full);
                    n_out_hit   = r_hit;
                    n_out_fault = r_fault;
                    n_accesses  = sat_inc(r_accesses);
                    if (r_hit) begin
                        n_hits = sat_inc(r_hits);
                    end
                    if (r_fault) begin
                        n_faults = sat_inc(r_faults);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_idx        <= '0;
            r_fifo_slot  <= '0;
            r_free_frame <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
            r_accesses   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_idx        <= n_idx;
            r_fifo_slot  <= n_fifo_slot;
            r_free_frame <= n_free_frame;
            r_hits       <= n_hits;
            r_faults     <= n_faults;
            r_accesses   <= n_accesses;
            r_out_valid  <= n_out_valid;
        end
        r_page      <= n_page;
        r_offset    <= n_offset;
        r_frame     <= n_frame;
        r_hit       <= n_hit;
        r_fault     <= n_fault;
        r_out_pa    <= n_out_pa;
        r_out_hit   <= n_out_hit;
        r_out_fault <= n_out_fault;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_phys_addr    = r_out_pa;
    assign o_tlb_hit      = r_out_hit;
    assign o_page_fault   = r_out_fault;
    assign o_hit_count    = r_hits;
    assign o_fault_count  = r_faults;
    assign o_access_count = r_accesses;

    // a result is never both a tlb hit and a page fault
    a_hit_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("result flagged as both tlb hit and page fault");

    // the page table is read only after a full tlb walk
    a_table_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TABLE) |-> ($past(r_state) == S_SCAN && $past(scan_last)))
        else $error("page table lookup without a complete tlb walk");

    // an accepted transaction starts the tlb walk at slot zero
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("accepted transaction did not start the tlb walk");

    // counts on a posted result cover that result
    a_counts_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_access_count != '0 && (!o_tlb_hit || o_hit_count != '0)
                     && (!o_page_fault || o_fault_count != '0)))
        else $error("running count does not include the posted result");

endmodule

FILE: verif/tlb_page_table_translator_unit_tb.sv
module tlb_page_table_translator_unit_tb;
    import tlbpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_PER_PHASE = 410;
    localparam int RECENT_DEPTH = 8;

    // one translation as seen on the result channel
    typedef struct packed {
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  faults;
        logic [CNT_W-1:0]  accesses;
    } t_translation;

    // directed stimulus row; known rows carry their result, the others use the predictor
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              known;
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  faults;
        logic [CNT_W-1:0]  accesses;
    } t_directed_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [ADDR_W-1:0] i_logical_address = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [ADDR_W-1:0] o_phys_addr;
    logic              o_tlb_hit;
    logic              o_page_fault;
    logic [CNT_W-1:0]  o_hit_count;
    logic [CNT_W-1:0]  o_fault_count;
    logic [CNT_W-1:0]  o_access_count;

    tlb_page_table_translator_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_logical_address  (i_logical_address),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_phys_addr        (o_phys_addr),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_hit_count        (o_hit_count),
        .o_fault_count      (o_fault_count),
        .o_access_count     (o_access_count)
    );

    // directed walk: first touches, tlb hits, fifo wrap, page-table hits after eviction
    t_directed_row directed_rows [23] = '{
        '{16'h0000, 1'b1, 16'h0000, 1'b0, 1'b1, 16'd0, 16'd1, 16'd1},
        '{16'h00FF, 1'b1, 16'h00FF, 1'b1, 1'b0, 16'd1, 16'd1, 16'd2},
        '{16'hFFFF, 1'b1, 16'h01FF, 1'b0, 1'b1, 16'd1, 16'd2, 16'd3},
        '{16'hFF00, 1'b1, 16'h0100, 1'b1, 1'b0, 16'd2, 16'd2, 16'd4},
        '{16'h0101, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0202, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0304, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0408, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0510, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0620, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0740, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0880, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h09FE, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0AFD, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0BFB, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0CF7, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0DEF, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0EDF, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0F33, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0012, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h1080, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'hFF7F, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'h0F55, 1'b0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0}
    };

    // translator model state
    logic [PAGE_W-1:0]    slot_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]   slot_frame [TLB_ENTRIES];
    bit                   slot_live  [TLB_ENTRIES];
    logic [FRAME_W-1:0]   page_frame    [PAGE_COUNT];
    bit                   page_resident [PAGE_COUNT];
    logic [FREE_W-1:0]    alloc_frame = '0;
    logic [TLB_IDX_W-1:0] refill_slot = '0;
    logic [CNT_W-1:0]     hits_seen = '0;
    logic [CNT_W-1:0]     faults_seen = '0;
    logic [CNT_W-1:0]     accesses_seen = '0;

    t_translation      pending_translations [$];
    logic [PAGE_W-1:0] recent_pages [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int calm_items = 0;
    int calm_cycles = 0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // translate one address and advance the model
    function automatic t_translation predict_xlate(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]  page;
        logic [OFF_W-1:0]   offset;
        logic [FRAME_W-1:0] frame;
        t_translation       res;
        int                 s;
        page   = PAGE_W'(addr >> OFF_W);
        offset = OFF_W'(addr);
        frame  = '0;
        res    = '0;
        // lowest matching live slot wins
        for (s = 0; s < TLB_ENTRIES; s++) begin
            if (!res.hit && slot_live[s] && slot_page[s] == page) begin
                res.hit = 1'b1;
                frame   = slot_frame[s];
            end
        end
        if (res.hit) begin
            hits_seen = bump_count(hits_seen);
        end else if (page_resident[page]) begin
            frame = page_frame[page];
        end else begin
            // demand allocation plus fifo refill of the tlb
            res.fault               = 1'b1;
            faults_seen             = bump_count(faults_seen);
            frame                   = alloc_frame[FRAME_W-1:0];
            alloc_frame             = alloc_frame + FREE_W'(1);
            page_frame[page]        = frame;
            page_resident[page]     = 1'b1;
            slot_page[refill_slot]  = page;
            slot_frame[refill_slot] = frame;
            slot_live[refill_slot]  = 1'b1;
            refill_slot             = refill_slot + TLB_IDX_W'(1);
        end
        accesses_seen = bump_count(accesses_seen);
        res.phys      = ADDR_W'(int'(frame) * PAGE_BYTES + int'(offset));
        res.hits      = hits_seen;
        res.faults    = faults_seen;
        res.accesses  = accesses_seen;
        return res;
    endfunction

    // drive one transaction, record its expected translation once accepted
    task automatic send_item(input logic [ADDR_W-1:0] addr, input bit known,
                             input t_translation want);
        t_translation pred;
        if (calm_items > 0) begin
            calm_items--;
        end else begin
            if ($urandom_range(0, 99) < 3) calm_items = $urandom_range(5, 20);
            if ($urandom_range(0, 99) < send_idle_pct) begin
                i_valid <= 1'b0;
                i_logical_address <= ADDR_W'($urandom);
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_logical_address <= addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = predict_xlate(addr);
        pending_translations.push_back(known ? want : pred);
        recent_pages.push_back(PAGE_W'(addr >> OFF_W));
        if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
    endtask

    // stop sending until every pending translation has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_translations.size() != 0) @(posedge i_clk);
    endtask

    // mostly reuse of recent or resident pages, the rest uniform addresses
    task automatic send_random(input int count);
        logic [PAGE_W-1:0] page;
        logic [ADDR_W-1:0] addr;
        int                pick;
        int                tries;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            addr = ADDR_W'($urandom);
            page = PAGE_W'(addr >> OFF_W);
            if (pick < 35 && recent_pages.size() > 0) begin
                page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            end else if (pick < 60) begin
                tries = 0;
                while (!page_resident[page] && tries < 8) begin
                    page = PAGE_W'($urandom);
                    tries++;
                end
            end
            addr = (ADDR_W'(page) << OFF_W) | ADDR_W'(OFF_W'(addr));
            send_item(addr, 1'b0, '0);
        end
    endtask

    // result side back-pressure, with quiet stretches
    always @(posedge i_clk) begin
        if (calm_cycles > 0) begin
            calm_cycles <= calm_cycles - 1;
            i_ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 99) < 3) calm_cycles <= $urandom_range(8, 40);
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_translation want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_translations.size() == 0) begin
                $error("result transaction with no expectation pending");
                error_count++;
            end else begin
                want = pending_translations.pop_front();
                check_field("phys_addr", want.phys, o_phys_addr);
                check_field("tlb_hit", want.hit, o_tlb_hit);
                check_field("page_fault", want.fault, o_page_fault);
                check_field("hit_count", want.hits, o_hit_count);
                check_field("fault_count", want.faults, o_fault_count);
                check_field("access_count", want.accesses, o_access_count);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_translation  want;
        t_directed_row row;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 22;
        recv_idle_pct = 67;
        foreach (directed_rows[r]) begin
            row  = directed_rows[r];
            want = '{row.phys, row.hit, row.fault, row.hits, row.faults, row.accesses};
            send_item(row.addr, row.known, want);
        end
        send_random(RANDOM_PER_PHASE);
        drain();

        // roles swapped
        send_idle_pct = 67;
        recv_idle_pct = 22;
        send_random(RANDOM_PER_PHASE);
        drain();

        // no idling: remaining random, a full page sweep, then 40 more random
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_PER_PHASE);
        for (int p = 0; p < PAGE_COUNT; p++) begin
            send_item((ADDR_W'(p) << OFF_W) | ADDR_W'(OFF_W'($urandom)), 1'b0, '0);
        end
        send_random(40);
        drain();

        repeat (TLB_ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/tlbpt_pkg.sv
sv/tlbpt_ram.sv
sv/tlbpt_tlb.sv
sv/tlb_page_table_translator_unit.sv
verif/tlb_page_table_translator_unit_tb.sv
